FILE: hw/rtl/cafilt_pkg.sv
// ----------------------------------------------------------------------------
// cafilt_pkg: shared types and constants of the CAN acceptance filter table
// Field widths, operation codes and the word that travels along the cell row.
// ----------------------------------------------------------------------------
package cafilt_pkg;

  localparam int ID_W      = 11;          // standard identifier
  localparam int WORD_W    = ID_W + 1;    // identifier plus remote bit
  localparam int IDX_W     = 5;           // entry_index / match_index
  localparam int DLC_W     = 4;
  localparam int PAY_W     = 64;
  localparam int CNT_W     = 6;           // entries_in_use register
  localparam int MAX_ENTRIES_DEF = 32;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(32);
  localparam logic [DLC_W-1:0] MAX_DLC   = DLC_W'(8);

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_FRAME    = 1'b1
  } op_t;

  // Word handed from cell to cell.
  typedef struct packed {
    op_t                op;
    logic               status;     // register word refused
    logic               wr_en;      // register word accepted, write at its slot
    logic [IDX_W-1:0]   index;      // slot for register words
    logic [WORD_W-1:0]  word;       // {remote, ident} of filter or frame
    logic [ID_W-1:0]    mask;       // filter mask, remote bit implied
    logic [DLC_W-1:0]   dlc;
    logic [PAY_W-1:0]   payload;
    logic               found;      // some earlier cell matched
    logic [IDX_W-1:0]   hit;        // first matching cell
    logic               hit_valid;  // that cell held a written entry
  } item_t;

endpackage

FILE: hw/rtl/cafilt_cell.sv
// ----------------------------------------------------------------------------
// cafilt_cell: one filter entry of the row
// Holds one entry, compares a passing frame word, writes its entry when a
// register word for its slot passes, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module cafilt_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [cafilt_pkg::CNT_W-1:0] eff_count,
  input  logic                         in_valid,
  input  cafilt_pkg::item_t            in_item,
  output logic                         out_valid,
  output cafilt_pkg::item_t            out_item
);
  import cafilt_pkg::*;

  localparam bit SEARCHABLE = CELL_IDX < 64;          // count register tops at 63
  localparam bit WRITABLE   = CELL_IDX < (1 << IDX_W);

  logic [WORD_W-1:0] ident_r;
  logic [WORD_W-1:0] mask_r;
  logic              valid_r;
  logic              stage_valid_r;
  item_t             item_r;
  item_t             item_nxt;
  logic              active;
  logic              match;
  logic              write_here;

  assign active = SEARCHABLE && (CNT_W'(CELL_IDX) < eff_count);
  assign match  = ((in_item.word ^ ident_r) & mask_r) == '0;

  assign write_here = advance && in_valid && (in_item.op == OP_REGISTER) &&
                      in_item.wr_en && WRITABLE &&
                      (in_item.index == IDX_W'(CELL_IDX));

  always_comb begin
    item_nxt = in_item;
    if (in_item.op == OP_FRAME && active && !in_item.found && match) begin
      item_nxt.found     = 1'b1;
      item_nxt.hit       = IDX_W'(CELL_IDX);
      item_nxt.hit_valid = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r       <= '0;
      mask_r        <= '1;
      valid_r       <= 1'b0;
      stage_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        stage_valid_r <= in_valid;
      end
      if (write_here) begin
        ident_r <= in_item.word;
        mask_r  <= {1'b1, in_item.mask};
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = stage_valid_r;
  assign out_item  = item_r;

endmodule

FILE: hw/rtl/can_rx_acceptance_filter_table.sv
// ----------------------------------------------------------------------------
// can_rx_acceptance_filter_table: standard-ID receive acceptance filter
// A row of MAX_ENTRIES filter cells; register words program entries, frame
// words find the first matching entry and are delivered if it was written.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in_     | in_valid / in_ready   | op, slot, filter fields, frame fields
//  out_    | out_valid / out_ready | status, delivered, match index, frame
//  cfg_    | cfg_valid / cfg_ready | entries_in_use (6 bits)
//
//  One word enters per cycle while in_ready is high; it walks the row one
//  cell per cycle while the row advances, and reaches out_valid through
//  the cell registers (one cell per entry) and then the output register.
//  A stalled output freezes the whole row; in_ready drops only while the
//  last cell holds a word and the output register is full and not taken.
//  Synchronous active-low reset restores the reset entries (ident 0, mask all
//  ones, not valid) and entries_in_use = 32. cfg_ready is always 1.
// ----------------------------------------------------------------------------
module can_rx_acceptance_filter_table #(
  parameter int MAX_ENTRIES = cafilt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cafilt_pkg::CNT_W-1:0]  cfg_entries_in_use,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [cafilt_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [cafilt_pkg::ID_W-1:0]   in_filter_ident,
  input  logic [cafilt_pkg::ID_W-1:0]   in_filter_mask,
  input  logic                          in_filter_remote,
  input  logic [cafilt_pkg::ID_W-1:0]   in_frame_ident,
  input  logic                          in_frame_remote,
  input  logic [cafilt_pkg::DLC_W-1:0]  in_frame_dlc_code,
  input  logic [cafilt_pkg::PAY_W-1:0]  in_frame_payload,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic                          out_delivered,
  output logic [cafilt_pkg::IDX_W-1:0]  out_match_index,
  output logic [cafilt_pkg::ID_W-1:0]   out_ident,
  output logic                          out_remote,
  output logic [cafilt_pkg::DLC_W-1:0]  out_length,
  output logic [cafilt_pkg::PAY_W-1:0]  out_payload
);
  import cafilt_pkg::*;

  // Largest count the 6-bit register can express, clipped to the table.
  localparam int CLIP = (MAX_ENTRIES > 63) ? 63 : MAX_ENTRIES;

  logic [CNT_W-1:0] entries_r;
  logic [CNT_W-1:0] eff_count;
  logic             advance;
  logic             refused;
  item_t            in_item;

  logic  chain_v [MAX_ENTRIES+1];
  item_t chain_d [MAX_ENTRIES+1];

  item_t last;
  logic  last_v;
  logic  deliver;
  logic  load_out;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               status_r;
  logic               delivered_r;
  logic [IDX_W-1:0]   match_index_r;
  logic [ID_W-1:0]    ident_r;
  logic               remote_r;
  logic [DLC_W-1:0]   length_r;
  logic [PAY_W-1:0]   payload_r;

  // --- configuration -------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries_r <= cfg_entries_in_use;
    end
  end

  // Count beyond the table searches and writes the whole table.
  assign eff_count = (entries_r > CNT_W'(CLIP)) ? CNT_W'(CLIP) : entries_r;

  // --- entry word ------------------------------------------------------------
  // Slot check is done once here; the slot's cell only sees wr_en.
  assign refused = {1'b0, in_entry_index} >= eff_count;

  always_comb begin
    in_item           = '0;
    in_item.op        = op_t'(in_op);
    in_item.index     = in_entry_index;
    in_item.dlc       = in_frame_dlc_code;
    in_item.payload   = in_frame_payload;
    if (op_t'(in_op) == OP_REGISTER) begin
      in_item.status = refused;
      in_item.wr_en  = !refused;
      in_item.word   = {in_filter_remote, in_filter_ident};
      in_item.mask   = in_filter_mask;
    end else begin
      in_item.word   = {in_frame_remote, in_frame_ident};
    end
  end

  // Whole row moves together; holds only when the last cell cannot unload.
  assign advance  = !last_v || !out_valid_r || out_ready;
  assign in_ready = advance;

  assign chain_v[0] = in_valid;
  assign chain_d[0] = in_item;

  // --- cell row --------------------------------------------------------------
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    cafilt_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .eff_count (eff_count),
      .in_valid  (chain_v[g]),
      .in_item   (chain_d[g]),
      .out_valid (chain_v[g+1]),
      .out_item  (chain_d[g+1])
    );
  end

  assign last_v = chain_v[MAX_ENTRIES];
  assign last   = chain_d[MAX_ENTRIES];

  // --- output register -------------------------------------------------------
  // A frame is handed on only when the first hit holds a written entry;
  // a hit on a reset entry swallows the frame but still reports its index.
  assign deliver  = (last.op == OP_FRAME) && last.found && last.hit_valid;
  assign load_out = advance && last_v;

  assign out_valid_nxt = (out_valid_r && !out_ready) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r      <= (last.op == OP_REGISTER) && last.status;
      delivered_r   <= deliver;
      match_index_r <= ((last.op == OP_FRAME) && last.found) ? last.hit : '0;
      ident_r       <= deliver ? last.word[ID_W-1:0] : '0;
      remote_r      <= deliver && last.word[WORD_W-1];
      length_r      <= (deliver && last.dlc <= MAX_DLC) ? last.dlc : '0;
      payload_r     <= deliver ? last.payload : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_delivered   = delivered_r;
  assign out_match_index = match_index_r;
  assign out_ident       = ident_r;
  assign out_remote      = remote_r;
  assign out_length      = length_r;
  assign out_payload     = payload_r;

  // --- checks ----------------------------------------------------------------
  a_ready_when_out_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_refused_not_delivered : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_delivered && out_match_index == '0)
    else $error("refused register word carries frame result");

  a_swallowed_is_clear : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_delivered |-> out_payload == '0 && out_ident == '0 &&
                                    out_length == '0 && !out_remote)
    else $error("undelivered word carries frame data");

  a_length_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_delivered |-> out_length <= MAX_DLC)
    else $error("delivered length above 8");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CAN acceptance filter table
// Sends a directed opening set and then random register and frame words
// under several entries_in_use settings. Each accepted input word is run
// through a bench-side copy of the filter table, and every result word must
// match the oldest outstanding prediction field by field. Both channels see
// random idle gaps, the output one long stall; each phase ends in a drain.
// ----------------------------------------------------------------------------
module tb_top;
  import cafilt_pkg::*;

  // One input word as seen on the in_ ports.
  typedef struct {
    op_t               op;
    logic [IDX_W-1:0]  entry_index;
    logic [ID_W-1:0]   filter_ident;
    logic [ID_W-1:0]   filter_mask;
    logic              filter_remote;
    logic [ID_W-1:0]   frame_ident;
    logic              frame_remote;
    logic [DLC_W-1:0]  frame_dlc_code;
    logic [PAY_W-1:0]  frame_payload;
  } rx_word_t;

  // One result word as seen on the out_ ports.
  typedef struct {
    logic              status;
    logic              delivered;
    logic [IDX_W-1:0]  match_index;
    logic [ID_W-1:0]   ident;
    logic              remote;
    logic [DLC_W-1:0]  length;
    logic [PAY_W-1:0]  payload;
  } verdict_t;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int LONG_HOLD   = 300;  // output stall, far longer than the row

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports (all inputs known from time zero)
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid          = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_entries_in_use = '0;

  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic              in_op             = 1'b0;
  logic [IDX_W-1:0]  in_entry_index    = '0;
  logic [ID_W-1:0]   in_filter_ident   = '0;
  logic [ID_W-1:0]   in_filter_mask    = '0;
  logic              in_filter_remote  = 1'b0;
  logic [ID_W-1:0]   in_frame_ident    = '0;
  logic              in_frame_remote   = 1'b0;
  logic [DLC_W-1:0]  in_frame_dlc_code = '0;
  logic [PAY_W-1:0]  in_frame_payload  = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_status;
  logic              out_delivered;
  logic [IDX_W-1:0]  out_match_index;
  logic [ID_W-1:0]   out_ident;
  logic              out_remote;
  logic [DLC_W-1:0]  out_length;
  logic [PAY_W-1:0]  out_payload;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  can_rx_acceptance_filter_table u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_entry_index     (in_entry_index),
    .in_filter_ident    (in_filter_ident),
    .in_filter_mask     (in_filter_mask),
    .in_filter_remote   (in_filter_remote),
    .in_frame_ident     (in_frame_ident),
    .in_frame_remote    (in_frame_remote),
    .in_frame_dlc_code  (in_frame_dlc_code),
    .in_frame_payload   (in_frame_payload),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_delivered      (out_delivered),
    .out_match_index    (out_match_index),
    .out_ident          (out_ident),
    .out_remote         (out_remote),
    .out_length         (out_length),
    .out_payload        (out_payload)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the filter table: {remote, ident} words, masks with the
  // remote bit forced on, written flags, and the entry count register.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] shadow_ident [TABLE_DEPTH];
  logic [WORD_W-1:0] shadow_mask  [TABLE_DEPTH];
  logic              shadow_valid [TABLE_DEPTH];
  logic [CNT_W-1:0]  shadow_count;

  rx_word_t    rx_backlog[$];       // words waiting for the driver
  verdict_t    pending_verdicts[$]; // predicted results, oldest first
  int unsigned mismatches = 0;

  // Traffic shaping knobs, set by the stimulus block.
  bit          quiet_mode    = 1'b0; // no gaps on either side
  int unsigned out_hold_asks = 0;    // requests for a long output stall
  int unsigned out_hold_done = 0;
  int unsigned out_stall     = 0;
  int unsigned send_gap      = 0;
  logic        in_fire       = 1'b0; // input word taken at the last rising edge

  // Searched/writable entries; counts above the table clamp to its depth.
  function automatic int unsigned live_entries();
    return (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
  endfunction

  // Apply one word to the shadow table and return the result it must give.
  function automatic verdict_t filter_table_apply(rx_word_t w);
    verdict_t    v;
    int unsigned n;
    logic [WORD_W-1:0] fw;
    bit          found;
    int unsigned hit;
    v     = '{default: '0};
    n     = live_entries();
    found = 1'b0;
    hit   = 0;
    if (w.op == OP_REGISTER) begin
      if (int'(w.entry_index) < n) begin
        shadow_ident[w.entry_index] = {w.filter_remote, w.filter_ident};
        shadow_mask[w.entry_index]  = {1'b1, w.filter_mask};
        shadow_valid[w.entry_index] = 1'b1;
      end else begin
        v.status = 1'b1;  // slot out of range: refused, table untouched
      end
    end else begin
      fw = {w.frame_remote, w.frame_ident};
      for (int i = 0; i < n && !found; i++) begin
        if (((fw ^ shadow_ident[i]) & shadow_mask[i]) == '0) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (found) begin
        v.match_index = IDX_W'(hit);
        // a hit on a never-written entry swallows the frame
        if (shadow_valid[hit]) begin
          v.delivered = 1'b1;
          v.ident     = w.frame_ident;
          v.remote    = w.frame_remote;
          v.length    = (w.frame_dlc_code <= MAX_DLC) ? w.frame_dlc_code : '0;
          v.payload   = w.frame_payload;
        end
      end
    end
    return v;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rx_word_t reg_word(int unsigned idx, int unsigned ident,
                                        int unsigned mask, bit remote);
    rx_word_t w;
    w.op             = OP_REGISTER;
    w.entry_index    = IDX_W'(idx);
    w.filter_ident   = ID_W'(ident);
    w.filter_mask    = ID_W'(mask);
    w.filter_remote  = remote;
    w.frame_ident    = ID_W'($urandom_range(0, 2047));
    w.frame_remote   = 1'($urandom_range(0, 1));
    w.frame_dlc_code = DLC_W'($urandom_range(0, 15));
    w.frame_payload  = {$urandom, $urandom};
    return w;
  endfunction

  function automatic rx_word_t frame_word(int unsigned ident, bit remote,
                                          int unsigned dlc, logic [PAY_W-1:0] pay);
    rx_word_t w;
    w                = reg_word($urandom_range(0, 31), $urandom_range(0, 2047),
                                $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
    w.op             = OP_FRAME;
    w.frame_ident    = ID_W'(ident);
    w.frame_remote   = remote;
    w.frame_dlc_code = DLC_W'(dlc);
    w.frame_payload  = pay;
    return w;
  endfunction

  // Random word. Half the frames are aimed at a table entry (masked-out bits
  // scrambled) so that hits, swallows and first-match ordering show up often.
  function automatic rx_word_t random_word();
    rx_word_t    w;
    int unsigned n;
    int unsigned pick;
    int unsigned mask;
    n = live_entries();
    case ($urandom_range(0, 3))
      0:       mask = 2047;
      1:       mask = 0;
      default: mask = $urandom_range(0, 2047);
    endcase
    if ($urandom_range(0, 9) < 3) begin
      pick = ($urandom_range(0, 3) == 0 || n == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(0, n - 1);
      w = reg_word(pick, $urandom_range(0, 2047), mask, 1'($urandom_range(0, 1)));
    end else begin
      w = frame_word($urandom_range(0, 2047), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 15), {$urandom, $urandom});
      if ($urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, TABLE_DEPTH - 1);
        w.frame_ident  = shadow_ident[pick][ID_W-1:0] ^
                         (ID_W'($urandom_range(0, 2047)) & ~shadow_mask[pick][ID_W-1:0]);
        w.frame_remote = shadow_ident[pick][ID_W];
      end
    end
    return w;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents words at the falling edge. A word stays up unchanged
  // until in_fire says it was taken; only then may the next one replace it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_words
    rx_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (rx_backlog.size() > 0) begin
        w = rx_backlog.pop_front();
        in_op             <= w.op;
        in_entry_index    <= w.entry_index;
        in_filter_ident   <= w.filter_ident;
        in_filter_mask    <= w.filter_mask;
        in_filter_remote  <= w.filter_remote;
        in_frame_ident    <= w.frame_ident;
        in_frame_remote   <= w.frame_remote;
        in_frame_dlc_code <= w.frame_dlc_code;
        in_frame_payload  <= w.frame_payload;
        in_valid          <= 1'b1;
        send_gap = idle_len();  // gap that follows this word's acceptance
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random ready gaps, plus the long hold when one is asked for.
  always @(negedge clk) begin : drive_ready
    int unsigned len;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold_done < out_hold_asks) begin
      out_hold_done++;
      out_stall = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      len = idle_len();
      if (len == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_stall = len - 1;
        out_ready <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, check a taken result word against the
  // oldest prediction, then predict for a taken input word. A word passes
  // through registered cells, so it never leaves in the cycle it enters.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    rx_word_t w;
    verdict_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status",      64'(want.status),      64'(out_status));
        check_field("delivered",   64'(want.delivered),   64'(out_delivered));
        check_field("match_index", 64'(want.match_index), 64'(out_match_index));
        check_field("ident",       64'(want.ident),       64'(out_ident));
        check_field("remote",      64'(want.remote),      64'(out_remote));
        check_field("length",      64'(want.length),      64'(out_length));
        check_field("payload",     want.payload,          out_payload);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      w.op             = op_t'(in_op);
      w.entry_index    = in_entry_index;
      w.filter_ident   = in_filter_ident;
      w.filter_mask    = in_filter_mask;
      w.filter_remote  = in_filter_remote;
      w.frame_ident    = in_frame_ident;
      w.frame_remote   = in_frame_remote;
      w.frame_dlc_code = in_frame_dlc_code;
      w.frame_payload  = in_frame_payload;
      pending_verdicts.push_back(filter_table_apply(w));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Wait until every queued word went in and every result came back.
  task automatic wait_drained();
    @(posedge clk);
    while (rx_backlog.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // Entry count write; only issued with the row empty.
  task automatic write_entry_count(int unsigned value);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_entries_in_use <= CNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_count = CNT_W'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) rx_backlog.push_back(random_word());
  endtask

  initial begin : stimulus
    int unsigned settle;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_ident[i] = '0;
      shadow_mask[i]  = '1;
      shadow_valid[i] = 1'b0;
    end
    shadow_count = CNT_RESET;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset table: only ident 0 data frames hit, and they are swallowed.
    rx_backlog.push_back(frame_word(0,    1'b0, 8,  '1));
    rx_backlog.push_back(frame_word(0,    1'b1, 0,  '0));
    rx_backlog.push_back(frame_word(2047, 1'b0, 15, 64'hA5A5_5A5A_0F0F_F0F0));
    // exact-match data entry, any-remote entry at the top, any-data entry
    rx_backlog.push_back(reg_word(0,  2047, 2047, 1'b0));
    rx_backlog.push_back(reg_word(31, 0,    0,    1'b1));
    rx_backlog.push_back(reg_word(5,  0,    0,    1'b0));
    rx_backlog.push_back(frame_word(2047, 1'b0, 9, {$urandom, $urandom}));
    rx_backlog.push_back(frame_word(2047, 1'b1, 8, {$urandom, $urandom}));
    rx_backlog.push_back(frame_word(0,    1'b0, 3, {$urandom, $urandom}));
    rx_backlog.push_back(frame_word(11'h123, 1'b0, 8, '1));
    // once entry 1 is rewritten, ident 0 falls through to reset entry 2
    rx_backlog.push_back(reg_word(1, 11'h555, 2047, 1'b0));
    rx_backlog.push_back(frame_word(0,       1'b0, 1, {$urandom, $urandom}));
    rx_backlog.push_back(frame_word(11'h555, 1'b0, 7, {$urandom, $urandom}));
    rx_backlog.push_back(reg_word(31, 2047, 2047, 1'b1));
    rx_backlog.push_back(frame_word(11'h100, 1'b1, 2, {$urandom, $urandom}));
    wait_drained();

    // No entries: every register word refused, no frame matches.
    write_entry_count(0);
    rx_backlog.push_back(reg_word(0, 11'h2AA, 2047, 1'b0));
    rx_backlog.push_back(frame_word(11'h555, 1'b0, 8, {$urandom, $urandom}));
    wait_drained();

    // Count above the table clamps to the full table.
    write_entry_count(63);
    rx_backlog.push_back(reg_word(31, 11'h3AA, 11'h0F0, 1'b1));
    rx_backlog.push_back(frame_word(11'h30A, 1'b1, 4, {$urandom, $urandom}));
    wait_drained();

    // Single entry: slot 1 refused, slot 0 written and searched.
    write_entry_count(1);
    rx_backlog.push_back(reg_word(1, 0, 0, 1'b0));
    rx_backlog.push_back(reg_word(0, 11'h7F0, 11'h7F0, 1'b0));
    rx_backlog.push_back(frame_word(11'h7F5, 1'b0, 6, {$urandom, $urandom}));
    rx_backlog.push_back(frame_word(11'h555, 1'b0, 6, {$urandom, $urandom}));
    wait_drained();

    // Random phases.
    write_entry_count(32);
    queue_random(90);
    wait_drained();

    write_entry_count($urandom_range(2, 31));
    queue_random(90);
    wait_drained();

    // Back-pressure: sender runs flat out while the output is held, so the
    // row fills and in_ready must drop; the drain after is a full pause.
    write_entry_count(63);
    queue_random(90);
    quiet_mode = 1'b1;
    @(posedge clk);
    out_hold_asks++;
    wait_drained();
    quiet_mode = 1'b0;

    write_entry_count($urandom_range(0, 63));
    queue_random(40);
    wait_drained();

    write_entry_count(32);
    queue_random(140);
    wait_drained();

    // Let any stray result word surface before the verdict.
    settle = 0;
    while (settle < TABLE_DEPTH + 10) begin
      @(posedge clk);
      settle++;
    end
    if (pending_verdicts.size() != 0) begin
      $error("%0d result words never arrived", pending_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cafilt_pkg.sv
hw/rtl/cafilt_cell.sv
hw/rtl/can_rx_acceptance_filter_table.sv
dv/tb_top.sv
